[rtl/insertion_sorter_assert.svh]
// Assertion macros for the insertion sorter.
// Each macro checks on the rising clock edge and is off while reset is held.
`ifndef INSERTION_SORTER_ASSERT_SVH
`define INSERTION_SORTER_ASSERT_SVH

`define ISORT_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

`define ISORT_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

[rtl/isort_pkg.sv]
`timescale 1ns / 1ps

package isort_pkg;

    localparam int CAPACITY = 16;
    localparam int VALUE_W  = 32;

    typedef logic signed [VALUE_W-1:0] t_value;

    typedef enum logic [1:0] {
        ST_FILL  = 2'b01,
        ST_DRAIN = 2'b10
    } t_state;

    typedef struct packed {
        logic ins;
        logic shift;
    } t_cell_ctrl;

endpackage

[rtl/insertion_sorter.sv]
// Each input beat is inserted into a row of compare-and-shift cells unless the row
// is full, so a run is taken at one beat per cycle with no stall while it fills.
// After the last beat, the run leaves from the head cell one beat per cycle unless
// stalled, first result in the next cycle; input is stalled until the run is out.
// Synchronous active-low reset empties the row and clears the overflow flag.
`timescale 1ns / 1ps

module insertion_sorter (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  isort_pkg::t_value i_value,
    input  logic              i_last,
    output logic              o_stall,
    output logic              o_valid,
    output isort_pkg::t_value o_sorted_value,
    output logic              o_last_out,
    output logic              o_overflowed,
    input  logic              i_stall
);
    import isort_pkg::*;

    `include "insertion_sorter_assert.svh"

    t_state     r_state;
    t_state     n_state;
    logic       r_dropped;
    logic       n_dropped;
    t_cell_ctrl w_ctrl;
    logic       w_in_acc;
    logic       w_out_acc;
    logic       w_full;

    t_value              w_value [CAPACITY];
    logic [CAPACITY-1:0] w_valid;
    logic [CAPACITY-1:0] w_take;

    assign w_in_acc  = i_valid && !o_stall;
    assign w_out_acc = o_valid && !i_stall;
    assign w_full    = w_valid[CAPACITY-1];

    assign w_ctrl.ins   = w_in_acc && !w_full;
    assign w_ctrl.shift = w_out_acc;

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        t_value w_prev_value;
        logic   w_prev_valid;
        logic   w_prev_take;
        t_value w_next_value;
        logic   w_next_valid;

        if (g == 0) begin : g_head
            assign w_prev_value = '0;
            assign w_prev_valid = 1'b1;
            assign w_prev_take  = 1'b0;
        end else begin : g_body
            assign w_prev_value = w_value[g-1];
            assign w_prev_valid = w_valid[g-1];
            assign w_prev_take  = w_take[g-1];
        end

        if (g == CAPACITY - 1) begin : g_tail
            assign w_next_value = '0;
            assign w_next_valid = 1'b0;
        end else begin : g_inner
            assign w_next_value = w_value[g+1];
            assign w_next_valid = w_valid[g+1];
        end

        isort_cell u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_ctrl       (w_ctrl),
            .i_new_value  (i_value),
            .i_prev_value (w_prev_value),
            .i_prev_valid (w_prev_valid),
            .i_prev_take  (w_prev_take),
            .i_next_value (w_next_value),
            .i_next_valid (w_next_valid),
            .o_value      (w_value[g]),
            .o_valid      (w_valid[g]),
            .o_take       (w_take[g])
        );
    end

    always_comb begin
        n_state   = r_state;
        n_dropped = r_dropped;
        unique case (r_state)
            ST_FILL: begin
                if (w_in_acc && w_full) begin
                    n_dropped = 1'b1;
                end
                if (w_in_acc && i_last) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (w_out_acc && o_last_out) begin
                    n_state   = ST_FILL;
                    n_dropped = 1'b0;
                end
            end
            default: begin
                n_state = ST_FILL;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_FILL;
            r_dropped <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_dropped <= n_dropped;
        end
    end

    assign o_stall        = (r_state != ST_FILL);
    assign o_valid        = (r_state == ST_DRAIN) && w_valid[0];
    assign o_sorted_value = w_value[0];
    assign o_last_out     = w_valid[0] && !w_valid[1];
    assign o_overflowed   = r_dropped;

    `ISORT_ASSERT_SAME(a_valid_prefix, 1'b1, (w_valid & (w_valid + 1'b1)) == '0, "valid cells not a prefix")
    `ISORT_ASSERT_SAME(a_head_order, o_valid && !o_last_out, w_value[0] <= w_value[1], "head cells out of order")
    `ISORT_ASSERT_NEXT(a_last_drains, w_in_acc && i_last, o_valid, "no result after last beat")
    `ISORT_ASSERT_NEXT(a_run_empty, w_out_acc && o_last_out, w_valid == '0, "store not empty after run")

endmodule

[rtl/isort_cell.sv]
`timescale 1ns / 1ps

module isort_cell (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  isort_pkg::t_cell_ctrl i_ctrl,
    input  isort_pkg::t_value     i_new_value,
    input  isort_pkg::t_value     i_prev_value,
    input  logic                  i_prev_valid,
    input  logic                  i_prev_take,
    input  isort_pkg::t_value     i_next_value,
    input  logic                  i_next_valid,
    output isort_pkg::t_value     o_value,
    output logic                  o_valid,
    output logic                  o_take
);
    import isort_pkg::*;

    t_value r_value;
    t_value n_value;
    logic   r_valid;
    logic   n_valid;
    logic   w_take;

    // A cell gives way when it is empty or holds a strictly larger value.
    assign w_take = !r_valid || (r_value > i_new_value);

    always_comb begin
        n_value = r_value;
        n_valid = r_valid;
        if (i_ctrl.shift) begin
            n_value = i_next_value;
            n_valid = i_next_valid;
        end else if (i_ctrl.ins && w_take) begin
            n_value = i_prev_take ? i_prev_value : i_new_value;
            n_valid = r_valid | i_prev_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    assign o_value = r_value;
    assign o_valid = r_valid;
    assign o_take  = w_take;

endmodule
